FILE: design/updatable_min_priority_queue_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the updatable min priority queue
// Concurrent checks clocked on clock and held off during reset.
// ---------------------------------------------------------------------------
`ifndef UPDATABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define UPDATABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define UPMQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// condition must never be seen outside reset
`define UPMQ_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define UPMQ_ASSERT(lbl, prop, msg)
`define UPMQ_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: design/upmq_pkg.sv
// ---------------------------------------------------------------------------
// upmq_pkg
// Shared constants, codes and types of the updatable min priority queue.
// ---------------------------------------------------------------------------
`default_nettype none

package upmq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int ID_WIDTH_DEFAULT    = 16;
   localparam int PRIO_WIDTH          = 32;

   // command codes on req_cmd
   localparam logic CMD_SET    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_REMOVE,
      OP_SET
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   // per-cell status seen by the neighbors
   typedef struct packed {
      logic valid;
      logic le;     // priority <= key at the last compare
      logic match;  // id == key at the last compare
   } cell_flags_type;

   // broadcast control to every cell
   typedef struct packed {
      logic        compare;
      cell_op_type op;
      logic        found;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: design/upmq_cell.sv
// ---------------------------------------------------------------------------
// upmq_cell
// One slot of the sorted chain: compares against the broadcast key, then
// keeps its entry, takes a neighbor's entry or takes the key.
// ---------------------------------------------------------------------------
`default_nettype none
`include "updatable_min_priority_queue_defines.svh"

module upmq_cell
   import upmq_pkg::*;
#(
   parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctrl_type                ctrl,
   input  logic [ID_WIDTH-1:0]          key_id,
   input  logic signed [PRIO_WIDTH-1:0] key_prio,
   input  logic                         at_match,
   input  logic                         left_at_match,
   input  cell_flags_type               left_flags,
   input  logic [ID_WIDTH-1:0]          left_id,
   input  logic signed [PRIO_WIDTH-1:0] left_prio,
   input  cell_flags_type               right_flags,
   input  logic [ID_WIDTH-1:0]          right_id,
   input  logic signed [PRIO_WIDTH-1:0] right_prio,
   output cell_flags_type               flags,
   output logic [ID_WIDTH-1:0]          id,
   output logic signed [PRIO_WIDTH-1:0] prio
);

   logic                         valid_ff, valid_in;
   logic                         le_ff, le_in;
   logic                         match_ff, match_in;
   logic [ID_WIDTH-1:0]          id_ff, id_in;
   logic signed [PRIO_WIDTH-1:0] prio_ff, prio_in;

   logic self_low, self_high, left_high, right_low;
   logic take_right, take_left, keep, new_valid;

   // low: stays ahead of the key, high: goes behind it; the moved entry is neither
   assign self_low  = valid_ff & le_ff & ~match_ff;
   assign self_high = valid_ff & ~le_ff & ~match_ff;
   assign left_high = left_flags.valid & ~left_flags.le & ~left_flags.match;
   assign right_low = right_flags.valid & right_flags.le & ~right_flags.match;

   assign take_right = at_match & right_low;
   assign take_left  = ~left_at_match & left_high;
   assign keep       = (~at_match & self_low) | (at_match & self_high);
   assign new_valid  = ctrl.found ? valid_ff : (valid_ff | left_flags.valid);

   always_comb begin
      valid_in = valid_ff;
      le_in    = le_ff;
      match_in = match_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      if (ctrl.compare) begin
         le_in    = valid_ff & (prio_ff <= key_prio);
         match_in = valid_ff & (id_ff == key_id);
      end
      case (ctrl.op)
         OP_REMOVE: begin
            valid_in = right_flags.valid;
            id_in    = right_id;
            prio_in  = right_prio;
         end
         OP_SET: begin
            valid_in = new_valid;
            if (take_right) begin
               id_in   = right_id;
               prio_in = right_prio;
            end else if (take_left) begin
               id_in   = left_id;
               prio_in = left_prio;
            end else if (!keep) begin
               id_in   = key_id;
               prio_in = key_prio;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         le_ff    <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         le_ff    <= le_in;
         match_ff <= match_in;
      end
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign flags = '{valid: valid_ff, le: le_ff, match: match_ff};
   assign id    = id_ff;
   assign prio  = prio_ff;

   // chain stays sorted toward the right neighbor
   `UPMQ_ASSERT(a_cell_sorted, (valid_ff && right_flags.valid) |-> (prio_ff <= right_prio), "cell order broken")

endmodule

`default_nettype wire

FILE: design/updatable_min_priority_queue.sv
// ---------------------------------------------------------------------------
// updatable_min_priority_queue
// Sorted chain of cells holding (id, priority), minimum at cell 0.
// ---------------------------------------------------------------------------
// Usage:
//   req_* channel carries one command item: req_cmd = CMD_SET inserts
//   req_item_id with req_item_priority (Q16.16), or moves the id if it is
//   already queued, placing it behind equal priorities. req_cmd =
//   CMD_REMOVE pops the minimum entry.
//   rsp_* channel returns exactly one item per command: popped entry (if
//   any), entry count after the command, and overflow when a new id hit a
//   full queue (that command is dropped).
//   Each command is compared in all cells, then shifted/inserted in all
//   cells, and its result is registered. One command is in flight at a
//   time: the next is not accepted before the compare-then-update pass
//   over the cell chain is done.
//   req_stall is high while a command is in flight. If rsp_stall holds a
//   result, the next command may still be accepted and compared; it waits
//   in the update step until the result register frees up.
//   Reset (synchronous, active high) empties the queue at once: all cells
//   invalid, count zero, no result pending.
// ---------------------------------------------------------------------------
`default_nettype none
`include "updatable_min_priority_queue_defines.svh"

module updatable_min_priority_queue
   import upmq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int ID_WIDTH    = ID_WIDTH_DEFAULT,
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   // command items
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [ID_WIDTH-1:0]          req_item_id,
   input  logic signed [PRIO_WIDTH-1:0] req_item_priority,
   // result items
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_popped_valid,
   output logic [ID_WIDTH-1:0]          rsp_popped_id,
   output logic signed [PRIO_WIDTH-1:0] rsp_popped_priority,
   output logic [COUNT_WIDTH-1:0]       rsp_entry_count,
   output logic                         rsp_overflow
);

   localparam logic [QUEUE_DEPTH-1:0] ALL_ONES = '1;

   // control
   state_type                    state_ff, state_in;
   logic                         cmd_ff, cmd_in;
   logic [ID_WIDTH-1:0]          key_id_ff, key_id_in;
   logic signed [PRIO_WIDTH-1:0] key_prio_ff, key_prio_in;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;
   cell_ctrl_type                cell_ctrl;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_popped_valid_ff, rsp_popped_valid_in;
   logic [ID_WIDTH-1:0]          rsp_popped_id_ff, rsp_popped_id_in;
   logic signed [PRIO_WIDTH-1:0] rsp_popped_priority_ff, rsp_popped_priority_in;
   logic [COUNT_WIDTH-1:0]       rsp_entry_count_ff, rsp_entry_count_in;
   logic                         rsp_overflow_ff, rsp_overflow_in;

   // chain wiring
   cell_flags_type               cell_flags  [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]          cell_id     [QUEUE_DEPTH];
   logic signed [PRIO_WIDTH-1:0] cell_prio   [QUEUE_DEPTH];
   cell_flags_type               left_flags  [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]          left_id     [QUEUE_DEPTH];
   logic signed [PRIO_WIDTH-1:0] left_prio   [QUEUE_DEPTH];
   cell_flags_type               right_flags [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]          right_id    [QUEUE_DEPTH];
   logic signed [PRIO_WIDTH-1:0] right_prio  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]       match_vec;
   logic [QUEUE_DEPTH-1:0]       valid_vec;
   logic [QUEUE_DEPTH-1:0]       at_match_vec;
   logic [QUEUE_DEPTH-1:0]       left_at_match_vec;

   logic found, full, empty, overflow, out_free, do_update;

   // ---------------------------------------------------------------------
   // Cell chain. Cell 0 sees a left neighbor that is valid and low, so it
   // never takes from the left; the last cell sees an empty right neighbor.
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_flags[i]        = '{valid: 1'b1, le: 1'b1, match: 1'b0};
         assign left_id[i]           = '0;
         assign left_prio[i]         = '0;
         assign left_at_match_vec[i] = 1'b0;
      end else begin : g_mid_left
         assign left_flags[i]        = cell_flags[i-1];
         assign left_id[i]           = cell_id[i-1];
         assign left_prio[i]         = cell_prio[i-1];
         assign left_at_match_vec[i] = at_match_vec[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_flags[i] = '0;
         assign right_id[i]    = '0;
         assign right_prio[i]  = '0;
      end else begin : g_mid_right
         assign right_flags[i] = cell_flags[i+1];
         assign right_id[i]    = cell_id[i+1];
         assign right_prio[i]  = cell_prio[i+1];
      end

      assign match_vec[i] = cell_flags[i].match;
      assign valid_vec[i] = cell_flags[i].valid;

      upmq_cell #(
         .ID_WIDTH (ID_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .key_id        (key_id_ff),
         .key_prio      (key_prio_ff),
         .at_match      (at_match_vec[i]),
         .left_at_match (left_at_match_vec[i]),
         .left_flags    (left_flags[i]),
         .left_id       (left_id[i]),
         .left_prio     (left_prio[i]),
         .right_flags   (right_flags[i]),
         .right_id      (right_id[i]),
         .right_prio    (right_prio[i]),
         .flags         (cell_flags[i]),
         .id            (cell_id[i]),
         .prio          (cell_prio[i])
      );
   end

   // ids in the chain are unique, so the match vector is one-hot or zero.
   // Subtracting one marks every cell below the match; the complement is
   // the "at or after the moved entry" mask that drives the left shift.
   assign found        = |match_vec;
   assign at_match_vec = found ? ~(match_vec - QUEUE_DEPTH'(1)) : '0;

   assign full     = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign overflow = (cmd_ff == CMD_SET) && !found && full;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer: idle -> compare -> update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff                 <= cmd_in;
      key_id_ff              <= key_id_in;
      key_prio_ff            <= key_prio_in;
      rsp_popped_valid_ff    <= rsp_popped_valid_in;
      rsp_popped_id_ff       <= rsp_popped_id_in;
      rsp_popped_priority_ff <= rsp_popped_priority_in;
      rsp_entry_count_ff     <= rsp_entry_count_in;
      rsp_overflow_ff        <= rsp_overflow_in;
   end

   always_comb begin
      state_in               = state_ff;
      cmd_in                 = cmd_ff;
      key_id_in              = key_id_ff;
      key_prio_in            = key_prio_ff;
      count_in               = count_ff;
      req_stall              = 1'b1;
      do_update              = 1'b0;
      cell_ctrl              = '{compare: 1'b0, op: OP_HOLD, found: found};
      rsp_valid_in           = rsp_valid_ff && rsp_stall;
      rsp_popped_valid_in    = rsp_popped_valid_ff;
      rsp_popped_id_in       = rsp_popped_id_ff;
      rsp_popped_priority_in = rsp_popped_priority_ff;
      rsp_entry_count_in     = rsp_entry_count_ff;
      rsp_overflow_in        = rsp_overflow_ff;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in      = req_cmd;
               key_id_in   = req_item_id;
               key_prio_in = req_item_priority;
               state_in    = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cell_ctrl.compare = 1'b1;
            state_in          = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               do_update              = 1'b1;
               state_in               = ST_IDLE;
               rsp_valid_in           = 1'b1;
               rsp_popped_valid_in    = 1'b0;
               rsp_popped_id_in       = '0;
               rsp_popped_priority_in = '0;
               rsp_overflow_in        = overflow;
               if (cmd_ff == CMD_REMOVE) begin
                  cell_ctrl.op = OP_REMOVE;
                  if (!empty) begin
                     rsp_popped_valid_in    = 1'b1;
                     rsp_popped_id_in       = cell_id[0];
                     rsp_popped_priority_in = cell_prio[0];
                     count_in               = count_ff - COUNT_WIDTH'(1);
                  end
               end else if (!overflow) begin
                  cell_ctrl.op = OP_SET;
                  if (!found) begin
                     count_in = count_ff + COUNT_WIDTH'(1);
                  end
               end
               rsp_entry_count_in = count_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_popped_valid    = rsp_popped_valid_ff;
   assign rsp_popped_id       = rsp_popped_id_ff;
   assign rsp_popped_priority = rsp_popped_priority_ff;
   assign rsp_entry_count     = rsp_entry_count_ff;
   assign rsp_overflow        = rsp_overflow_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // at most one cell may hold the key's id
   `UPMQ_ASSERT(a_match_onehot, (state_ff == ST_UPDATE) |-> $onehot0(match_vec), "duplicate id in queue")
   // valid cells form a solid run from cell 0 of length count
   `UPMQ_ASSERT(a_valid_run, valid_vec == ~(ALL_ONES << count_ff), "valid run does not match count")
   // a pop from a non-empty queue drops the count by one
   `UPMQ_ASSERT(a_pop_count, (do_update && cmd_ff == CMD_REMOVE && !empty) |=> (count_ff == $past(count_ff) - COUNT_WIDTH'(1)), "pop did not shrink count")
   // a reported overflow always goes with a full queue
   `UPMQ_ASSERT(a_overflow_full, (rsp_valid_ff && rsp_overflow_ff) |-> full, "overflow without full queue")

endmodule

`default_nettype wire

FILE: sim/updatable_min_priority_queue_tb.sv
// ---------------------------------------------------------------------------
// updatable_min_priority_queue_tb
// Self-checking bench for the sorted min queue with update key. Commands
// go in on the req_ channel; every result item is compared field by field
// with the sorted in-bench shadow's prediction or a directed script value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module updatable_min_priority_queue_tb
   import upmq_pkg::*;
();

   localparam int DEPTH       = QUEUE_DEPTH_DEFAULT;
   localparam int ID_W        = ID_WIDTH_DEFAULT;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int N_RANDOM    = 650;
   localparam int POOL_SIZE   = 96;
   localparam int STALL_PCT   = 23;
   localparam int QUIET_LIMIT = 4000;   // cycles with no handshake at all
   localparam int TAIL_CYCLES = 8;      // margin after the last result is checked

   // one result item as the block reports it
   typedef struct packed {
      logic                         popped_valid;
      logic [ID_W-1:0]              popped_id;
      logic signed [PRIO_WIDTH-1:0] popped_priority;
      logic [COUNT_W-1:0]           entry_count;
      logic                         overflow;
   } queue_result_type;

   // one row of the directed script; reps > 1 steps the id by one per item
   // and spreads the priority over five neighboring integer values
   typedef struct {
      logic                  cmd;
      logic [ID_W-1:0]       id;
      logic [PRIO_WIDTH-1:0] prio;
      int                    reps;
      bit                    typed;   // want holds the result, no prediction
      queue_result_type      want;
   } cmd_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_cmd = CMD_SET;
   logic [ID_W-1:0]              req_item_id = '0;
   logic signed [PRIO_WIDTH-1:0] req_item_priority = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_popped_valid;
   logic [ID_W-1:0]              rsp_popped_id;
   logic signed [PRIO_WIDTH-1:0] rsp_popped_priority;
   logic [COUNT_W-1:0]           rsp_entry_count;
   logic                         rsp_overflow;

   // sorted shadow of the queue, minimum at index 0
   logic [ID_W-1:0]              shadow_ids [0:DEPTH-1];
   logic signed [PRIO_WIDTH-1:0] shadow_prios [0:DEPTH-1];
   int                           shadow_count = 0;

   queue_result_type awaited_results [$];
   logic [ID_W-1:0] id_pool [0:POOL_SIZE-1];

   bit calm = 1'b0;           // no gaps and no stalls while set
   int error_count = 0;
   int commands_sent = 0;
   int results_checked = 0;
   int pops_seen = 0;
   int overflows_seen = 0;
   int peak_count = 0;
   int quiet_cycles = 0;

   localparam queue_result_type EMPTY_POP = '{1'b0, '0, '0, '0, 1'b0};

   // directed part: extremes, ties, update-in-place, empty and full queue
   cmd_row_type script [0:19] = '{
      // remove on the empty queue after reset; id/priority are ignored
      '{CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1, EMPTY_POP},
      '{CMD_SET,    16'h0000, 32'h8000_0000, 1, 1'b1, '{1'b0, '0, '0, 7'd1, 1'b0}},
      '{CMD_SET,    16'hFFFF, 32'h7FFF_FFFF, 1, 1'b1, '{1'b0, '0, '0, 7'd2, 1'b0}},
      '{CMD_SET,    16'h1234, 32'h0000_0000, 1, 1'b1, '{1'b0, '0, '0, 7'd3, 1'b0}},
      '{CMD_SET,    16'h5678, 32'h0000_0000, 1, 1'b0, '0},
      // same priority again: 1234 moves behind 5678
      '{CMD_SET,    16'h1234, 32'h0000_0000, 1, 1'b0, '0},
      // update down to the minimum: lands behind id 0
      '{CMD_SET,    16'hFFFF, 32'h8000_0000, 1, 1'b0, '0},
      '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 1, 1'b1,
        '{1'b1, 16'h0000, 32'h8000_0000, 7'd3, 1'b0}},
      '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 3, 1'b0, '0},
      '{CMD_REMOVE, 16'h1234, 32'h0005_0000, 1, 1'b1, EMPTY_POP},
      '{CMD_SET,    16'hA5A5, 32'h0001_8000, 1, 1'b0, '0},
      '{CMD_SET,    16'h5A5A, 32'hFFFF_8000, 1, 1'b0, '0},
      // fill to exactly DEPTH entries with many ties
      '{CMD_SET,    16'h0100, 32'hFFFE_0000, DEPTH - 2, 1'b0, '0},
      // new id into a full queue is dropped
      '{CMD_SET,    16'hBEEF, 32'h0000_0000, 1, 1'b1, '{1'b0, '0, '0, 7'd64, 1'b1}},
      // id already present in a full queue is a plain update
      '{CMD_SET,    16'hA5A5, 32'h8000_0000, 1, 1'b1, '{1'b0, '0, '0, 7'd64, 1'b0}},
      '{CMD_SET,    16'h0100, 32'h7FFF_FFFF, 1, 1'b0, '0},
      '{CMD_REMOVE, 16'h0000, 32'h0000_0000, DEPTH, 1'b0, '0},
      '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 1, 1'b1, EMPTY_POP},
      '{CMD_SET,    16'h8000, 32'hFFFF_FFFF, 1, 1'b0, '0},
      '{CMD_REMOVE, 16'h7FFF, 32'h0000_0001, 1, 1'b0, '0}
   };

   updatable_min_priority_queue #(
      .QUEUE_DEPTH(DEPTH),
      .ID_WIDTH(ID_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_item_id(req_item_id),
      .req_item_priority(req_item_priority),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_popped_valid(rsp_popped_valid),
      .rsp_popped_id(rsp_popped_id),
      .rsp_popped_priority(rsp_popped_priority),
      .rsp_entry_count(rsp_entry_count),
      .rsp_overflow(rsp_overflow)
   );

   always #4 clock = ~clock;

   // --- shadow queue ------------------------------------------------------

   // close the gap left by the entry at pos
   function automatic void drop_slot(input int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_ids[i]   = shadow_ids[i + 1];
         shadow_prios[i] = shadow_prios[i + 1];
      end
      shadow_count--;
   endfunction

   // insert behind every entry with priority <= the new one
   function automatic void place_sorted(input logic [ID_W-1:0] id,
                                        input logic signed [PRIO_WIDTH-1:0] prio);
      int pos;
      pos = 0;
      while (pos < shadow_count && shadow_prios[pos] <= prio)
         pos++;
      for (int i = shadow_count; i > pos; i--) begin
         shadow_ids[i]   = shadow_ids[i - 1];
         shadow_prios[i] = shadow_prios[i - 1];
      end
      shadow_ids[pos]   = id;
      shadow_prios[pos] = prio;
      shadow_count++;
   endfunction

   // apply one command to the shadow and return the result it should give
   function automatic queue_result_type apply_command(input logic cmd,
                                                      input logic [ID_W-1:0] id,
                                                      input logic signed [PRIO_WIDTH-1:0] prio);
      queue_result_type r;
      int hit;
      r = '0;
      if (cmd == CMD_REMOVE) begin
         if (shadow_count > 0) begin
            r.popped_valid    = 1'b1;
            r.popped_id       = shadow_ids[0];
            r.popped_priority = shadow_prios[0];
            drop_slot(0);
         end
      end else begin
         hit = -1;
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_ids[i] == id) begin
               hit = i;
               break;
            end
         end
         if (hit >= 0) begin
            drop_slot(hit);
            place_sorted(id, prio);
         end else if (shadow_count >= DEPTH) begin
            r.overflow = 1'b1;
         end else begin
            place_sorted(id, prio);
         end
      end
      r.entry_count = COUNT_W'(shadow_count);
      return r;
   endfunction

   // --- driving -----------------------------------------------------------

   // random gap, then hold the item until it is taken; the expectation is
   // queued at the edge that accepts it
   task automatic issue_command(input logic cmd, input logic [ID_W-1:0] id,
                                input logic [PRIO_WIDTH-1:0] prio, input bit typed,
                                input queue_result_type want);
      queue_result_type predicted;
      while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_item_id       <= id;
      req_item_priority <= prio;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = apply_command(cmd, id, prio);
      awaited_results.push_back(typed ? want : predicted);
      commands_sent++;
      if (shadow_count > peak_count)
         peak_count = shadow_count;
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
   end

   // --- checking ----------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      if (error_count < 40)
         $display("[%0t] result %0d: %s is %0h, expected %0h",
                  $realtime, results_checked, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      queue_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_popped_valid, rsp_popped_id, rsp_popped_priority,
                 rsp_entry_count, rsp_overflow};
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result item", longint'(got), 0);
         end else begin
            want = awaited_results.pop_front();
            if (got.popped_valid !== want.popped_valid)
               report_mismatch("popped_valid", got.popped_valid, want.popped_valid);
            if (got.popped_id !== want.popped_id)
               report_mismatch("popped_id", got.popped_id, want.popped_id);
            if (got.popped_priority !== want.popped_priority)
               report_mismatch("popped_priority", got.popped_priority,
                               want.popped_priority);
            if (got.entry_count !== want.entry_count)
               report_mismatch("entry_count", got.entry_count, want.entry_count);
            if (got.overflow !== want.overflow)
               report_mismatch("overflow", got.overflow, want.overflow);
            if (want.popped_valid)
               pops_seen++;
            if (want.overflow)
               overflows_seen++;
         end
         results_checked++;
      end
   end

   // watchdog: a hung handshake on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, awaited_results.size());
         $display("updatable_min_priority_queue_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --- stimulus ----------------------------------------------------------

   initial begin : stimulus
      int set_pct;
      int r;
      logic cmd;
      logic [ID_W-1:0] id;
      logic [PRIO_WIDTH-1:0] prio;

      // small id pool so sets hit present ids often and the queue fills
      for (int i = 0; i < POOL_SIZE; i++)
         id_pool[i] = ID_W'($urandom);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         for (int rep = 0; rep < script[i].reps; rep++)
            issue_command(script[i].cmd, script[i].id + ID_W'(rep),
                          script[i].prio + 32'((rep % 5) * 65536),
                          script[i].typed, script[i].want);
      end

      // random part in phases of 100: fill, mixed, drain, heavy fill
      for (int k = 0; k < N_RANDOM; k++) begin
         case ((k / 100) % 4)
            0:       set_pct = 80;
            1:       set_pct = 55;
            2:       set_pct = 30;
            default: set_pct = 92;
         endcase
         calm = (k >= 300 && k < 450);
         cmd  = ($urandom_range(0, 99) < set_pct) ? CMD_SET : CMD_REMOVE;
         id   = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : ID_W'($urandom);
         r = $urandom_range(0, 99);
         if (r < 35) begin
            // integer priorities -3..3, lots of ties
            prio = {16'(int'($urandom_range(0, 6)) - 3), 16'h0000};
         end else if (r < 70) begin
            prio = $urandom;
         end else if (r < 80) begin
            case ($urandom_range(0, 3))
               0:       prio = 32'h8000_0000;
               1:       prio = 32'h7FFF_FFFF;
               2:       prio = 32'h0000_0000;
               default: prio = 32'hFFFF_FFFF;
            endcase
         end else begin
            // near-ties that differ only in the fraction
            prio = {16'(int'($urandom_range(0, 6)) - 3), 16'($urandom)};
         end
         issue_command(cmd, id, prio, 1'b0, '0);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d commands, checked %0d results: %0d pops, %0d full-queue drops",
               commands_sent, results_checked, pops_seen, overflows_seen);
      $display("queue depth peaked at %0d of %0d, %0d mismatches",
               peak_count, DEPTH, error_count);
      if (error_count == 0)
         $display("updatable_min_priority_queue_tb OK");
      else
         $display("updatable_min_priority_queue_tb NOT OK");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/upmq_pkg.sv
design/upmq_cell.sv
design/updatable_min_priority_queue.sv
sim/updatable_min_priority_queue_tb.sv
